FILE: hdl/prs2d_pkg.sv
// prs2d_pkg: widths, register indexes, shared types and the sine table
// for the point rotate/scale pipeline. No dependencies.
package prs2d_pkg;

  localparam int COORD_W    = 24;
  localparam int TRIG_W     = 16;
  localparam int TRIG_F     = TRIG_W - 1;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 8;
  localparam int ANGLE_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  // datapath widths, each just wide enough for the exact value
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = TRIG_W + DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int SHR_W      = SUM_W - TRIG_F;
  localparam int ROT_W      = SHR_W + 1;
  localparam int ERR_W      = ROT_W + 1;
  localparam int SPROD_W    = ERR_W + SCALE_W;
  localparam int SSHR_W     = SPROD_W - SCALE_FRAC;
  localparam int OUT_FULL_W = SSHR_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RC_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RC_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SC_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SC_Y    = 3'd5;

  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << SCALE_FRAC);

  localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90);
  localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270);
  localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360);

  localparam logic signed [TRIG_W-1:0] TRIG_MAX = {1'b0, {TRIG_F{1'b1}}};

  localparam int SINE_N     = 91;
  localparam int SINE_IDX_W = $clog2(SINE_N);

  localparam logic [63:0] PI_Q32  = 64'h3_243F_6A89;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef logic [SINE_N-1:0][TRIG_F-1:0] sine_tab_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic                    last;
  } rot_pt_t;

  // sin(k deg) in Q30 by a Horner-form series, rounded to Q1.TRIG_F and
  // clamped below 1.0; evaluated at elaboration only
  function automatic logic [TRIG_F-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] top;
    x  = (64'(k) * PI_Q32 + 64'd360) / 64'd720;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd210;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t + (64'd1 << 29)) >> 30;
    m  = (s + (64'd1 << (29 - TRIG_F))) >> (30 - TRIG_F);
    top = (64'd1 << TRIG_F) - 64'd1;
    if (m > top) begin
      m = top;
    end
    return m[TRIG_F-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int unsigned k = 0; k < SINE_N; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: hdl/prs2d_trig.sv
// prs2d_trig: turns the configured angle into registered sine and cosine
// in Q1.15 using the first-quadrant table. Depends on prs2d_pkg.
module prs2d_trig (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [prs2d_pkg::ANGLE_W-1:0]   angle_i,
  output prs2d_pkg::trig_t                trig_o
);

  function automatic logic signed [prs2d_pkg::TRIG_W-1:0] sine_deg(
    input logic [prs2d_pkg::ANGLE_W-1:0] a
  );
    logic [prs2d_pkg::ANGLE_W-1:0]    k9;
    logic                             neg;
    logic signed [prs2d_pkg::TRIG_W-1:0] mag;
    if (a <= prs2d_pkg::DEG_90) begin
      k9  = a;
      neg = 1'b0;
    end else if (a <= prs2d_pkg::DEG_180) begin
      k9  = prs2d_pkg::DEG_180 - a;
      neg = 1'b0;
    end else if (a <= prs2d_pkg::DEG_270) begin
      k9  = a - prs2d_pkg::DEG_180;
      neg = 1'b1;
    end else begin
      k9  = prs2d_pkg::DEG_360 - a;
      neg = 1'b1;
    end
    mag = {1'b0, prs2d_pkg::SINE_TAB[k9[prs2d_pkg::SINE_IDX_W-1:0]]};
    return neg ? -mag : mag;
  endfunction

  logic [prs2d_pkg::ANGLE_W-1:0] ang_a;
  logic [prs2d_pkg::ANGLE_W-1:0] ang_b;
  logic [prs2d_pkg::ANGLE_W-1:0] ang_b_raw;
  prs2d_pkg::trig_t              trig_d;
  prs2d_pkg::trig_t              trig_q;

  // fold angles 360..511 once, then cos(a) = sin(a + 90)
  always_comb begin
    ang_a     = (angle_i >= prs2d_pkg::DEG_360) ? angle_i - prs2d_pkg::DEG_360 : angle_i;
    ang_b_raw = ang_a + prs2d_pkg::DEG_90;
    ang_b     = (ang_b_raw >= prs2d_pkg::DEG_360) ? ang_b_raw - prs2d_pkg::DEG_360
                                                  : ang_b_raw;
    trig_d.sin_v = sine_deg(ang_a);
    trig_d.cos_v = sine_deg(ang_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q.sin_v <= '0;
      trig_q.cos_v <= prs2d_pkg::TRIG_MAX;
    end else begin
      trig_q <= trig_d;
    end
  end

  assign trig_o = trig_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(angle_i) == '0 |-> trig_q.sin_v == '0 && trig_q.cos_v == prs2d_pkg::TRIG_MAX)
    else $error("zero angle does not give unit rotation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_q.cos_v == prs2d_pkg::TRIG_MAX |-> trig_q.sin_v == '0)
    else $error("full cosine with non-zero sine");

endmodule

FILE: hdl/prs2d_rotate.sv
// prs2d_rotate: three-stage rotation about the rotation centre
// (difference, products, shift and re-centre). Depends on prs2d_pkg.
module prs2d_rotate (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [prs2d_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [prs2d_pkg::COORD_W-1:0] point_y_i,
  input  logic                                 last_point_i,
  input  logic signed [prs2d_pkg::COORD_W-1:0] rc_x_i,
  input  logic signed [prs2d_pkg::COORD_W-1:0] rc_y_i,
  input  prs2d_pkg::trig_t                     trig_i,
  output logic                                 out_valid_o,
  input  logic                                 down_ready_i,
  output prs2d_pkg::rot_pt_t                   pt_o
);

  logic v0_q, v1_q, v2_q;
  logic en0, en1, en2;

  logic signed [prs2d_pkg::DIFF_W-1:0] dx_q, dy_q;
  logic                                last0_q, last1_q;
  logic signed [prs2d_pkg::PROD_W-1:0] cdx_q, sdy_q, sdx_q, cdy_q;
  logic signed [prs2d_pkg::SUM_W-1:0]  sum_x, sum_y;
  prs2d_pkg::rot_pt_t                  pt_d, pt_q;

  assign en2 = !v2_q || down_ready_i;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_ready_o = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  // stage 0: offset from the rotation centre
  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      dx_q    <= prs2d_pkg::DIFF_W'(point_x_i) - prs2d_pkg::DIFF_W'(rc_x_i);
      dy_q    <= prs2d_pkg::DIFF_W'(point_y_i) - prs2d_pkg::DIFF_W'(rc_y_i);
      last0_q <= last_point_i;
    end
  end

  // stage 1: the four products
  always_ff @(posedge clk_i) begin
    if (en1 && v0_q) begin
      cdx_q   <= trig_i.cos_v * dx_q;
      sdy_q   <= trig_i.sin_v * dy_q;
      sdx_q   <= trig_i.sin_v * dx_q;
      cdy_q   <= trig_i.cos_v * dy_q;
      last1_q <= last0_q;
    end
  end

  // stage 2: sum, floor shift by the sine fraction, back to absolute position
  always_comb begin
    sum_x = prs2d_pkg::SUM_W'(cdx_q) - prs2d_pkg::SUM_W'(sdy_q);
    sum_y = prs2d_pkg::SUM_W'(sdx_q) + prs2d_pkg::SUM_W'(cdy_q);
    pt_d.x = prs2d_pkg::ROT_W'($signed(sum_x[prs2d_pkg::SUM_W-1:prs2d_pkg::TRIG_F]))
           + prs2d_pkg::ROT_W'(rc_x_i);
    pt_d.y = prs2d_pkg::ROT_W'($signed(sum_y[prs2d_pkg::SUM_W-1:prs2d_pkg::TRIG_F]))
           + prs2d_pkg::ROT_W'(rc_y_i);
    pt_d.last = last1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pt_q <= pt_d;
    end
  end

  assign out_valid_o = v2_q;
  assign pt_o        = pt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !down_ready_i |=> v2_q && $stable(pt_q))
    else $error("rotated point lost while held");

endmodule

FILE: hdl/prs2d_scale.sv
// prs2d_scale: three-stage scaling about the scaling centre with final
// saturation; its last stage is the output register. Depends on prs2d_pkg.
module prs2d_scale (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  prs2d_pkg::rot_pt_t                   pt_i,
  input  logic signed [prs2d_pkg::SCALE_W-1:0] scale_i,
  input  logic signed [prs2d_pkg::COORD_W-1:0] sc_x_i,
  input  logic signed [prs2d_pkg::COORD_W-1:0] sc_y_i,
  output logic                                 out_valid_o,
  input  logic                                 down_ready_i,
  output logic signed [prs2d_pkg::COORD_W-1:0] out_x_o,
  output logic signed [prs2d_pkg::COORD_W-1:0] out_y_o,
  output logic                                 out_last_o
);

  localparam logic signed [prs2d_pkg::COORD_W-1:0] CMAX =
    {1'b0, {(prs2d_pkg::COORD_W-1){1'b1}}};
  localparam logic signed [prs2d_pkg::COORD_W-1:0] CMIN =
    {1'b1, {(prs2d_pkg::COORD_W-1){1'b0}}};

  function automatic logic signed [prs2d_pkg::COORD_W-1:0] sat(
    input logic signed [prs2d_pkg::OUT_FULL_W-1:0] v
  );
    if (v > prs2d_pkg::OUT_FULL_W'(CMAX)) begin
      return CMAX;
    end else if (v < prs2d_pkg::OUT_FULL_W'(CMIN)) begin
      return CMIN;
    end
    return v[prs2d_pkg::COORD_W-1:0];
  endfunction

  logic v0_q, v1_q, v2_q;
  logic en0, en1, en2;

  logic signed [prs2d_pkg::ERR_W-1:0]      ex_q, ey_q;
  logic signed [prs2d_pkg::SPROD_W-1:0]    px_q, py_q;
  logic                                    last0_q, last1_q, last2_q;
  logic signed [prs2d_pkg::OUT_FULL_W-1:0] full_x, full_y;
  logic signed [prs2d_pkg::COORD_W-1:0]    ox_q, oy_q;

  assign en2 = !v2_q || down_ready_i;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_ready_o = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  // stage 0: offset from the scaling centre
  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      ex_q    <= prs2d_pkg::ERR_W'(pt_i.x) - prs2d_pkg::ERR_W'(sc_x_i);
      ey_q    <= prs2d_pkg::ERR_W'(pt_i.y) - prs2d_pkg::ERR_W'(sc_y_i);
      last0_q <= pt_i.last;
    end
  end

  // stage 1: multiply by the Q8.8 factor
  always_ff @(posedge clk_i) begin
    if (en1 && v0_q) begin
      px_q    <= ex_q * scale_i;
      py_q    <= ey_q * scale_i;
      last1_q <= last0_q;
    end
  end

  // stage 2: floor shift, re-centre, clamp
  always_comb begin
    full_x = prs2d_pkg::OUT_FULL_W'(
               $signed(px_q[prs2d_pkg::SPROD_W-1:prs2d_pkg::SCALE_FRAC]))
           + prs2d_pkg::OUT_FULL_W'(sc_x_i);
    full_y = prs2d_pkg::OUT_FULL_W'(
               $signed(py_q[prs2d_pkg::SPROD_W-1:prs2d_pkg::SCALE_FRAC]))
           + prs2d_pkg::OUT_FULL_W'(sc_y_i);
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      ox_q    <= sat(full_x);
      oy_q    <= sat(full_y);
      last2_q <= last1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_last_o  = last2_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v0_q && v1_q && v2_q)
    else $error("scale pipeline refuses requests with a bubble inside");

endmodule

FILE: hdl/point_rotate_scale_2d.sv
// point_rotate_scale_2d: rotate a Q16.8 point about one centre, then scale
// it about another, through the rotate stages and then the scale stages.
// Throughput: one point per cycle; stalls hold every stage, bubbles are
// squeezed out. An angle write goes to angle_q, then the sine/cosine register.
// Reset: pipeline empty, angle 0, factor 1.0, both centres at the origin.
// Depends on prs2d_pkg, prs2d_trig, prs2d_rotate, prs2d_scale.
module point_rotate_scale_2d (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [prs2d_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [prs2d_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [prs2d_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [prs2d_pkg::COORD_W-1:0]  point_y_i,
  input  logic                                  last_point_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [prs2d_pkg::COORD_W-1:0]  out_x_o,
  output logic signed [prs2d_pkg::COORD_W-1:0]  out_y_o,
  output logic                                  out_last_o
);

  logic [prs2d_pkg::ANGLE_W-1:0]        angle_q;
  logic signed [prs2d_pkg::SCALE_W-1:0] scale_q;
  logic signed [prs2d_pkg::COORD_W-1:0] rc_x_q, rc_y_q, sc_x_q, sc_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      scale_q <= prs2d_pkg::SCALE_ONE;
      rc_x_q  <= '0;
      rc_y_q  <= '0;
      sc_x_q  <= '0;
      sc_y_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prs2d_pkg::REG_ANGLE: angle_q <= cfg_data_i[prs2d_pkg::ANGLE_W-1:0];
        prs2d_pkg::REG_SCALE: scale_q <= cfg_data_i[prs2d_pkg::SCALE_W-1:0];
        prs2d_pkg::REG_RC_X:  rc_x_q  <= cfg_data_i[prs2d_pkg::COORD_W-1:0];
        prs2d_pkg::REG_RC_Y:  rc_y_q  <= cfg_data_i[prs2d_pkg::COORD_W-1:0];
        prs2d_pkg::REG_SC_X:  sc_x_q  <= cfg_data_i[prs2d_pkg::COORD_W-1:0];
        prs2d_pkg::REG_SC_Y:  sc_y_q  <= cfg_data_i[prs2d_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  prs2d_pkg::trig_t   trig;
  prs2d_pkg::rot_pt_t rot_pt;
  logic               in_ready;
  logic               rot_valid;
  logic               scale_ready;

  prs2d_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .angle_i (angle_q),
    .trig_o  (trig)
  );

  prs2d_rotate u_rotate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .rc_x_i       (rc_x_q),
    .rc_y_i       (rc_y_q),
    .trig_i       (trig),
    .out_valid_o  (rot_valid),
    .down_ready_i (scale_ready),
    .pt_o         (rot_pt)
  );

  prs2d_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (rot_valid),
    .in_ready_o   (scale_ready),
    .pt_i         (rot_pt),
    .scale_i      (scale_q),
    .sc_x_i       (sc_x_q),
    .sc_y_i       (sc_y_q),
    .out_valid_o  (out_valid_o),
    .down_ready_i (!out_stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_last_o   (out_last_o)
  );

  assign in_stall_o = !in_ready;

endmodule
